// ===== hw/rtl/tts_pkg.sv =====
package tts_pkg;

	localparam int SLOTS_DEF   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int RUN_W       = $clog2(MAX_RESULTS + 1);
	localparam int HANDLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int PEND_W      = 8;
	localparam int SLOT_FW     = 3;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ADD      = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_ADDED   = 3'd0,
		K_FULL    = 3'd1,
		K_RUN     = 3'd2,
		K_DELETED = 3'd3,
		K_EMPTY   = 3'd4,
		K_TICK    = 3'd5,
		K_NONE    = 3'd6
	} kind_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] task_handle;
		logic [TIME_W-1:0]   first_delay;
		logic [TIME_W-1:0]   period;
		logic [SLOT_FW-1:0]  slot;
	} request_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_FW-1:0]  slot_index;
		logic [HANDLE_W-1:0] run_handle;
		logic                last;
	} result_t;

	// source of the result loaded into the output register
	typedef enum logic [2:0] {
		SEL_ADDED,
		SEL_FULL,
		SEL_TICK,
		SEL_NONE,
		SEL_RUN_MID,
		SEL_RUN_LAST,
		SEL_DELETED,
		SEL_EMPTY
	} res_sel_t;

	typedef struct packed {
		logic     latch;
		logic     idx_inc;
		logic     tick_upd;
		logic     add_wr;
		logic     disp_take;
		logic     del_clr;
		logic     push;
		res_sel_t push_sel;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cur_valid;
		logic cur_pend_nz;
		logic last_idx;
		logic hold_valid;
		logic runs_next_full;
		logic can_push;
		logic del_hit;
	} status_t;

endpackage

// ===== hw/rtl/tts_stream_if.sv =====
interface tts_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tick_task_scheduler_table_top.sv =====
// Channel   Dir  Payload              Notes
// request   in   tts_pkg::request_t   op, task_handle, first_delay, period, slot
// result    out  tts_pkg::result_t    kind, slot_index, run_handle, last
//
// One request at a time. Tick, add and dispatch walk the table one slot per cycle
// unless a result waits on a full result register (add stops early at the first free
// slot); delete goes straight to its slot. The single slot-table read port sets this rate.
// arst_n clears every slot valid bit and all control state at once; no clearing pass.
// The result register holds while result.ready is low; the walk then stalls only
// when a further result must be loaded, and a new request is taken meanwhile.
module tick_task_scheduler_table_top #(
	parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tts_stream_if.sink   request,
	tts_stream_if.source result
);

	tts_pkg::cmd_t    cmd;
	tts_pkg::status_t st;
	tts_pkg::request_t req_data;
	tts_pkg::result_t  res_data;

	assign req_data = request.data;
	assign result.data = res_data;

	// sequencer: walk control, result ordering, stall on full result register
	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_op    (req_data.op),
		.req_ready (request.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// slot table, walk index, run hold register and result register
	tts_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.st        (st),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (res_data)
	);

endmodule

// ===== hw/rtl/tts_ctrl.sv =====
module tts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  tts_pkg::op_t      req_op,
	output logic              req_ready,
	input  tts_pkg::status_t  st,
	output tts_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   found;

	assign req_ready = (state_q == S_IDLE);
	assign found     = st.cur_valid && st.cur_pend_nz;

	always_comb begin
		cmd      = '0;
		cmd.push_sel = tts_pkg::SEL_TICK;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = (req_op == tts_pkg::OP_DELETE) ? S_FIN : S_WALK;
				end
			end
			S_WALK: begin
				case (st.op)
					tts_pkg::OP_TICK: begin
						cmd.tick_upd = 1'b1;
						if (st.last_idx) state_d = S_FIN;
						else cmd.idx_inc = 1'b1;
					end
					tts_pkg::OP_ADD: begin
						if (!st.cur_valid) begin
							if (st.can_push) begin
								cmd.add_wr   = 1'b1;
								cmd.push     = 1'b1;
								cmd.push_sel = tts_pkg::SEL_ADDED;
								state_d      = S_IDLE;
							end
						end else if (st.last_idx) begin
							state_d = S_FIN;
						end else begin
							cmd.idx_inc = 1'b1;
						end
					end
					tts_pkg::OP_DISPATCH: begin
						if (found) begin
							// previous run goes out as a middle result before the hold reloads
							if (!st.hold_valid || st.can_push) begin
								cmd.push      = st.hold_valid;
								cmd.push_sel  = tts_pkg::SEL_RUN_MID;
								cmd.disp_take = 1'b1;
								if (st.last_idx || st.runs_next_full) state_d = S_FIN;
								else cmd.idx_inc = 1'b1;
							end
						end else if (st.last_idx) begin
							state_d = S_FIN;
						end else begin
							cmd.idx_inc = 1'b1;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_FIN: begin
				if (st.can_push) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
					case (st.op)
						tts_pkg::OP_TICK: cmd.push_sel = tts_pkg::SEL_TICK;
						tts_pkg::OP_ADD:  cmd.push_sel = tts_pkg::SEL_FULL;
						tts_pkg::OP_DISPATCH: begin
							cmd.push_sel = st.hold_valid ? tts_pkg::SEL_RUN_LAST
							                             : tts_pkg::SEL_NONE;
						end
						default: begin
							cmd.del_clr  = st.del_hit;
							cmd.push_sel = st.del_hit ? tts_pkg::SEL_DELETED
							                          : tts_pkg::SEL_EMPTY;
						end
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/tts_datapath.sv =====
module tts_datapath #(
	parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tts_pkg::request_t  req_data,
	input  tts_pkg::cmd_t      cmd,
	output tts_pkg::status_t   st,
	output logic               res_valid,
	input  logic               res_ready,
	output tts_pkg::result_t   res_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// slot table
	logic                         valid_q  [SLOTS];
	logic [tts_pkg::HANDLE_W-1:0] handle_q [SLOTS];
	logic [tts_pkg::TIME_W-1:0]   cnt_q    [SLOTS];
	logic [tts_pkg::TIME_W-1:0]   per_q    [SLOTS];
	logic [tts_pkg::PEND_W-1:0]   pend_q   [SLOTS];

	// latched request
	tts_pkg::request_t req_q;

	logic [IDX_W-1:0]             idx_q;
	logic [tts_pkg::RUN_W-1:0]    nrun_q;
	logic                         hold_valid_q;
	logic [tts_pkg::SLOT_FW-1:0]  hold_idx_q;
	logic [tts_pkg::HANDLE_W-1:0] hold_handle_q;
	logic                         res_valid_q;
	tts_pkg::result_t             res_q;

	logic [IDX_W-1:0]             addr;
	logic                         in_range;
	logic                         cur_valid;
	tts_pkg::result_t             res_d;

	assign addr      = (req_q.op == tts_pkg::OP_DELETE) ? IDX_W'(req_q.slot) : idx_q;
	assign in_range  = (32'(req_q.slot) < SLOTS);
	assign cur_valid = valid_q[addr];

	always_comb begin
		st                = '0;
		st.op             = req_q.op;
		st.cur_valid      = cur_valid;
		st.cur_pend_nz    = (pend_q[addr] != '0);
		st.last_idx       = (idx_q == IDX_W'(SLOTS - 1));
		st.hold_valid     = hold_valid_q;
		st.runs_next_full = (nrun_q == tts_pkg::RUN_W'(tts_pkg::MAX_RESULTS - 1));
		st.can_push       = !res_valid_q || res_ready;
		st.del_hit        = in_range && cur_valid;
	end

	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		case (cmd.push_sel)
			tts_pkg::SEL_ADDED: begin
				res_d.kind       = tts_pkg::K_ADDED;
				res_d.slot_index = tts_pkg::SLOT_FW'(idx_q);
				res_d.run_handle = req_q.task_handle;
			end
			tts_pkg::SEL_FULL: res_d.kind = tts_pkg::K_FULL;
			tts_pkg::SEL_TICK: res_d.kind = tts_pkg::K_TICK;
			tts_pkg::SEL_NONE: res_d.kind = tts_pkg::K_NONE;
			tts_pkg::SEL_RUN_MID, tts_pkg::SEL_RUN_LAST: begin
				res_d.kind       = tts_pkg::K_RUN;
				res_d.slot_index = hold_idx_q;
				res_d.run_handle = hold_handle_q;
				res_d.last       = (cmd.push_sel == tts_pkg::SEL_RUN_LAST);
			end
			tts_pkg::SEL_DELETED: begin
				res_d.kind       = tts_pkg::K_DELETED;
				res_d.slot_index = req_q.slot;
				res_d.run_handle = handle_q[addr];
			end
			tts_pkg::SEL_EMPTY: begin
				res_d.kind       = tts_pkg::K_EMPTY;
				res_d.slot_index = req_q.slot;
			end
			default: res_d.kind = tts_pkg::K_NONE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
			idx_q        <= '0;
			nrun_q       <= '0;
			hold_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.latch) begin
				idx_q        <= '0;
				nrun_q       <= '0;
				hold_valid_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.add_wr) valid_q[addr] <= 1'b1;
			if (cmd.del_clr) valid_q[addr] <= 1'b0;
			if (cmd.disp_take) begin
				nrun_q       <= nrun_q + 1'b1;
				hold_valid_q <= 1'b1;
				if (per_q[addr] == '0) valid_q[addr] <= 1'b0;  // one-shot frees itself
			end
			if (cmd.push && cmd.push_sel == tts_pkg::SEL_RUN_LAST) hold_valid_q <= 1'b0;
			if (cmd.push) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req_data;
		if (cmd.push) res_q <= res_d;
		if (cmd.tick_upd && cur_valid) begin
			if (cnt_q[addr] == '0) begin
				if (pend_q[addr] != '1) pend_q[addr] <= pend_q[addr] + 1'b1;
				cnt_q[addr] <= per_q[addr];
			end else begin
				cnt_q[addr] <= cnt_q[addr] - 1'b1;
			end
		end
		if (cmd.add_wr) begin
			handle_q[addr] <= req_q.task_handle;
			cnt_q[addr]    <= req_q.first_delay;
			per_q[addr]    <= req_q.period;
			pend_q[addr]   <= '0;
		end
		if (cmd.disp_take) begin
			pend_q[addr]  <= pend_q[addr] - 1'b1;
			hold_idx_q    <= tts_pkg::SLOT_FW'(idx_q);
			hold_handle_q <= handle_q[addr];
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// ===== hw/rtl/tts_checker.sv =====
module tts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              res_valid,
	input logic              res_ready,
	input tts_pkg::result_t  res_data
);

	// one request in flight: ready drops right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken on consecutive cycles");

	// only run results may be followed by more results of the same request
	a_mid_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> res_data.kind == tts_pkg::K_RUN)
		else $error("non-final result that is not a run");

	// no kind code beyond the defined set is ever produced
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.kind <= tts_pkg::K_NONE)
		else $error("undefined result kind");

	// held result stays put while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

endmodule

bind tick_task_scheduler_table_top tts_checker u_tts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

// ===== dv/tick_task_scheduler_table_top_test.sv =====
`timescale 1ns / 100ps

module tick_task_scheduler_table_top_test;

	localparam int TBL_SLOTS          = tts_pkg::SLOTS_DEF;
	localparam int HW                 = tts_pkg::HANDLE_W;
	localparam int TW                 = tts_pkg::TIME_W;
	localparam int SW                 = tts_pkg::SLOT_FW;
	// tick and dispatch walk the whole table, add walks up to the first free slot
	localparam int DRAIN_CYCLES       = 4 * (TBL_SLOTS + 2);
	// long receiver hold-off, long enough to back the block up into its request port
	localparam int RESULT_HOLD_CYCLES = 300;
	// no transfer on either channel for this long means the block is hung
	localparam int WATCHDOG_LIMIT     = 4000;
	localparam int RANDOM_ITEMS       = 220;

	logic clk;
	logic arst_n;

	tts_stream_if #(.payload_t(tts_pkg::request_t)) request_ch ();
	tts_stream_if #(.payload_t(tts_pkg::result_t))  result_ch ();

	tick_task_scheduler_table_top #(
		.SLOTS(TBL_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch)
	);

	// shadow copy of the slot table
	logic                        tbl_valid     [TBL_SLOTS];
	logic [HW-1:0]               tbl_handle    [TBL_SLOTS];
	logic [TW-1:0]               tbl_countdown [TBL_SLOTS];
	logic [TW-1:0]               tbl_period    [TBL_SLOTS];
	logic [tts_pkg::PEND_W-1:0]  tbl_pending   [TBL_SLOTS];

	tts_pkg::result_t awaited_results[$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	bit idle_enable  = 1'b1;   // random gaps on both channels
	bit hold_results = 1'b0;   // request for one long hold-off on the result side

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Expected-result builder
	// ------------------------------------------------------------------
	function automatic void expect_result(input tts_pkg::kind_t kind,
			input logic [SW-1:0] idx, input logic [HW-1:0] handle, input logic last);
		tts_pkg::result_t res;
		res.kind       = kind;
		res.slot_index = idx;
		res.run_handle = handle;
		res.last       = last;
		awaited_results.push_back(res);
	endfunction

	function automatic void free_slot(input int i);
		tbl_valid[i]     = 1'b0;
		tbl_handle[i]    = '0;
		tbl_countdown[i] = '0;
		tbl_period[i]    = '0;
		tbl_pending[i]   = '0;
	endfunction

	// Applies one accepted request to the shadow table and queues the results it
	// must produce, in order.
	function automatic void predict_table_op(input tts_pkg::request_t req);
		int               i;
		int               runs;
		bit               done;
		bit               have_run;
		tts_pkg::result_t held_run;
		runs     = 0;
		done     = 1'b0;
		have_run = 1'b0;
		held_run = '0;
		case (req.op)
			tts_pkg::OP_TICK: begin
				for (i = 0; i < TBL_SLOTS; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_countdown[i] == '0) begin
							if (tbl_pending[i] != 8'hFF)
								tbl_pending[i] = tbl_pending[i] + 1'b1;
							tbl_countdown[i] = tbl_period[i];
						end else begin
							tbl_countdown[i] = tbl_countdown[i] - 1'b1;
						end
					end
				end
				expect_result(tts_pkg::K_TICK, '0, '0, 1'b1);
			end
			tts_pkg::OP_ADD: begin
				for (i = 0; i < TBL_SLOTS && !done; i++) begin
					if (!tbl_valid[i]) begin
						tbl_valid[i]     = 1'b1;
						tbl_handle[i]    = req.task_handle;
						tbl_countdown[i] = req.first_delay;
						tbl_period[i]    = req.period;
						tbl_pending[i]   = '0;
						expect_result(tts_pkg::K_ADDED, i[SW-1:0], req.task_handle, 1'b1);
						done = 1'b1;
					end
				end
				if (!done)
					expect_result(tts_pkg::K_FULL, '0, '0, 1'b1);
			end
			tts_pkg::OP_DISPATCH: begin
				// each run is queued once the next is known, so the final one gets last
				for (i = 0; i < TBL_SLOTS && runs < tts_pkg::MAX_RESULTS; i++) begin
					if (tbl_valid[i] && tbl_pending[i] != '0) begin
						if (have_run)
							awaited_results.push_back(held_run);
						held_run.kind       = tts_pkg::K_RUN;
						held_run.slot_index = i[SW-1:0];
						held_run.run_handle = tbl_handle[i];
						held_run.last       = 1'b0;
						have_run            = 1'b1;
						runs++;
						tbl_pending[i] = tbl_pending[i] - 1'b1;
						// one-shot: freed after its run, leftover runs dropped
						if (tbl_period[i] == '0)
							free_slot(i);
					end
				end
				if (have_run) begin
					held_run.last = 1'b1;
					awaited_results.push_back(held_run);
				end else begin
					expect_result(tts_pkg::K_NONE, '0, '0, 1'b1);
				end
			end
			default: begin
				if (int'(req.slot) < TBL_SLOTS && tbl_valid[req.slot]) begin
					expect_result(tts_pkg::K_DELETED, req.slot, tbl_handle[req.slot], 1'b1);
					free_slot(int'(req.slot));
				end else begin
					expect_result(tts_pkg::K_EMPTY, req.slot, '0, 1'b1);
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// unused fields carry random noise; the block must ignore them
	function automatic tts_pkg::request_t noisy_request(input tts_pkg::op_t op);
		tts_pkg::request_t req;
		req.op          = op;
		req.task_handle = HW'($urandom);
		req.first_delay = $urandom;
		req.period      = $urandom;
		req.slot        = SW'($urandom);
		return req;
	endfunction

	// Called at the edge of the previous transfer (or after reset). Valid is
	// either kept high with new data or dropped for a gap: one update per edge.
	task automatic send_request(input tts_pkg::request_t req);
		int gap;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data  <= req;
		do
			@(posedge clk);
		while (!request_ch.ready);
		predict_table_op(req);
	endtask

	task automatic send_add(input logic [HW-1:0] handle, input logic [TW-1:0] delay,
			input logic [TW-1:0] period);
		tts_pkg::request_t req;
		req             = noisy_request(tts_pkg::OP_ADD);
		req.task_handle = handle;
		req.first_delay = delay;
		req.period      = period;
		send_request(req);
	endtask

	task automatic send_delete(input logic [SW-1:0] slot);
		tts_pkg::request_t req;
		req      = noisy_request(tts_pkg::OP_DELETE);
		req.slot = slot;
		send_request(req);
	endtask

	// mostly short countdowns so slots actually fire; sometimes huge ones
	function automatic logic [TW-1:0] pick_tick_count();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return TW'($urandom_range(0, 3));
		else if (pick < 8)
			return $urandom;
		else
			return 32'hFFFF_FFFF - TW'($urandom_range(0, 3));
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	// ready: random low bursts, one long hold-off on request, else high
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_ch.ready <= 1'b0;
				repeat (RESULT_HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		tts_pkg::result_t exp_res;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, actual kind=%0d slot=%0d handle=%h last=%b",
					$realtime, result_ch.data.kind, result_ch.data.slot_index,
					result_ch.data.run_handle, result_ch.data.last);
			end else begin
				exp_res = awaited_results.pop_front();
				if (result_ch.data.kind !== exp_res.kind) begin
					mismatches++;
					$display("%0t: kind expected %0d actual %0d", $realtime,
						exp_res.kind, result_ch.data.kind);
				end
				if (result_ch.data.slot_index !== exp_res.slot_index) begin
					mismatches++;
					$display("%0t: slot_index expected %0d actual %0d", $realtime,
						exp_res.slot_index, result_ch.data.slot_index);
				end
				if (result_ch.data.run_handle !== exp_res.run_handle) begin
					mismatches++;
					$display("%0t: run_handle expected %h actual %h", $realtime,
						exp_res.run_handle, result_ch.data.run_handle);
				end
				if (result_ch.data.last !== exp_res.last) begin
					mismatches++;
					$display("%0t: last expected %b actual %b", $realtime,
						exp_res.last, result_ch.data.last);
				end
			end
		end
	end

	// hang detector: counts cycles without any transfer
	always @(posedge clk) begin
		if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[tick_task_scheduler_table_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// empty table: nothing ready, deletes hit free slots, tick is a no-op
	task automatic test_empty_table();
		send_request(noisy_request(tts_pkg::OP_DISPATCH));
		send_request(noisy_request(tts_pkg::OP_TICK));
		send_delete(3'd0);
		send_delete(3'd7);
	endtask

	// fill every slot with extreme handles, delays and periods, then overflow
	task automatic test_fill_table();
		send_add(16'h0000, 32'h0000_0000, 32'h0000_0000);   // one-shot, due at once
		send_add(16'hFFFF, 32'h0000_0000, 32'h0000_0001);
		send_add(16'h5AA5, 32'h0000_0001, 32'h0000_0000);   // one-shot, one tick late
		send_add(HW'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_add(HW'($urandom), 32'h0000_0002, 32'hFFFF_FFFF);
		send_add(16'hA55A, 32'h0000_0000, 32'h0000_0002);
		send_add(HW'($urandom), 32'h0000_0003, 32'h0000_0000);
		send_add(HW'($urandom), 32'hFFFF_FFFE, 32'h0000_0003);
		send_add(HW'($urandom), $urandom, $urandom);   // table full
	endtask

	// several slots ready per dispatch; one-shots must drop out
	task automatic test_ticks_and_dispatch();
		send_request(noisy_request(tts_pkg::OP_TICK));
		send_request(noisy_request(tts_pkg::OP_DISPATCH));
		send_request(noisy_request(tts_pkg::OP_TICK));
		send_request(noisy_request(tts_pkg::OP_TICK));
		send_request(noisy_request(tts_pkg::OP_DISPATCH));
	endtask

	// delete a live slot, a slot freed by dispatch, then sweep the table clean
	task automatic test_delete();
		int s;
		send_delete(3'd3);
		send_delete(3'd0);
		for (s = 0; s < 8; s++)
			send_delete(s[SW-1:0]);
	endtask

	// weighted random mix; one long result hold-off a third of the way in, no gaps at the end
	task automatic test_random_mix(input int count);
		int n;
		int pick;
		for (n = 0; n < count; n++) begin
			if (n == count / 3)
				hold_results = 1'b1;
			if (n == count - count / 5)
				idle_enable = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_request(noisy_request(tts_pkg::OP_TICK));
			else if (pick < 65)
				send_request(noisy_request(tts_pkg::OP_DISPATCH));
			else if (pick < 85)
				send_add(HW'($urandom), pick_tick_count(), pick_tick_count());
			else
				send_delete(SW'($urandom_range(0, 7)));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int i;
		arst_n           <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.data  <= '0;
		for (i = 0; i < TBL_SLOTS; i++)
			free_slot(i);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_table();
		test_ticks_and_dispatch();
		test_delete();
		test_random_mix(RANDOM_ITEMS);

		request_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		// catch any stray trailing result
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[tick_task_scheduler_table_top] OK");
		else
			$display("[tick_task_scheduler_table_top] ERROR");
		$finish;
	end

endmodule
